>>> hdl/lbgd_pkg.sv
// shared types, constants and register codes of the ladder button gesture detector
package lbgd_pkg;

  localparam int unsigned NUM_LADDERS     = 2;
  localparam int unsigned BTNS_PER_LADDER = 3;
  localparam int unsigned BTN_COUNT       = NUM_LADDERS * BTNS_PER_LADDER;

  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned MS_W     = 16;
  localparam int unsigned EVENT_W  = 3;
  localparam int unsigned BTN_W    = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // debounce time for ladder decisions and for a valid click, in ms
  localparam logic [TIME_W-1:0] DEBOUNCE_MS    = 32'd50;
  // period of repeated hold events after the long press, in ms
  localparam logic [MS_W-1:0]   HOLD_REPEAT_MS = 16'd200;

  // ladder decisions: no button, or one of the three ladder buttons
  localparam logic [BTN_W-1:0] BTN_NONE   = 2'd0;
  localparam logic [BTN_W-1:0] BTN_FIRST  = 2'd1;
  localparam logic [BTN_W-1:0] BTN_SECOND = 2'd2;
  localparam logic [BTN_W-1:0] BTN_THIRD  = 2'd3;

  typedef enum logic [EVENT_W-1:0] {
    EV_NONE   = 3'd0,
    EV_SHORT  = 3'd1,
    EV_DOUBLE = 3'd2,
    EV_LONG   = 3'd3,
    EV_HOLD   = 3'd4
  } event_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RELEASED_MIN    = 3'd0,
    CFG_FIRST_MAX       = 3'd1,
    CFG_SECOND_MIN      = 3'd2,
    CFG_SECOND_MAX      = 3'd3,
    CFG_THIRD_MIN       = 3'd4,
    CFG_THIRD_MAX       = 3'd5,
    CFG_LONG_PRESS_MS   = 3'd6,
    CFG_DOUBLE_CLICK_MS = 3'd7
  } cfg_idx_t;

  localparam logic [SAMPLE_W-1:0] RST_RELEASED_MIN    = 12'd3800;
  localparam logic [SAMPLE_W-1:0] RST_FIRST_MAX       = 12'd400;
  localparam logic [SAMPLE_W-1:0] RST_SECOND_MIN      = 12'd1000;
  localparam logic [SAMPLE_W-1:0] RST_SECOND_MAX      = 12'd1800;
  localparam logic [SAMPLE_W-1:0] RST_THIRD_MIN       = 12'd2200;
  localparam logic [SAMPLE_W-1:0] RST_THIRD_MAX       = 12'd3000;
  localparam logic [MS_W-1:0]     RST_LONG_PRESS_MS   = 16'd1000;
  localparam logic [MS_W-1:0]     RST_DOUBLE_CLICK_MS = 16'd300;

endpackage

>>> hdl/lbgd_if.sv
// channel interfaces: sample input, gesture result and register write
interface lbgd_in_if;
  import lbgd_pkg::*;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] ladder_a_sample;
  logic [SAMPLE_W-1:0] ladder_b_sample;
  logic [TIME_W-1:0]   now_ms;
  logic [BTN_COUNT-1:0] ack_mask;

  modport source (output valid, ladder_a_sample, ladder_b_sample, now_ms, ack_mask,
                  input ready);
  modport sink   (input valid, ladder_a_sample, ladder_b_sample, now_ms, ack_mask,
                  output ready);
endinterface

interface lbgd_out_if;
  import lbgd_pkg::*;
  logic               valid;
  logic               ready;
  logic [EVENT_W-1:0] event_b1;
  logic [EVENT_W-1:0] event_b2;
  logic [EVENT_W-1:0] event_b3;
  logic [EVENT_W-1:0] event_b4;
  logic [EVENT_W-1:0] event_b5;
  logic [EVENT_W-1:0] event_b6;
  logic [BTN_COUNT-1:0] pressed_mask;
  logic [BTN_W-1:0]   ladder_a_button;
  logic [BTN_W-1:0]   ladder_b_button;

  modport source (output valid, event_b1, event_b2, event_b3, event_b4, event_b5, event_b6,
                  pressed_mask, ladder_a_button, ladder_b_button, input ready);
  modport sink   (input valid, event_b1, event_b2, event_b3, event_b4, event_b5, event_b6,
                  pressed_mask, ladder_a_button, ladder_b_button, output ready);
endinterface

interface lbgd_cfg_if;
  import lbgd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  addr;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

>>> hdl/ladder_button_gesture_detector.sv
// top level: two resistor-ladder ADC classifiers with debounce and six button gesture machines
//
// Each accepted sample item carries one 12-bit sample per ladder, a millisecond timestamp and an
// acknowledge mask, and produces exactly one result transfer: the pending event of each of the six
// buttons (0 none, 1 short, 2 double, 3 long, 4 hold), the pressed mask and the two debounced
// ladder decisions. Ladder A feeds buttons 1 to 3, ladder B buttons 4 to 6. Events of buttons whose
// ack bit is set are cleared right after they are reported in that result. The block takes one
// item per clock cycle: an item is captured in an input register, and a single update pass over
// the ladder and button state then writes the result register. The result register decouples
// the two sides, so one more item is taken into the input register while a finished result still
// waits for its transfer; throughput drops only while the result side stalls. The register port
// is always ready; registers should be written only while no item is in flight. All time
// differences wrap modulo 2^32.
module ladder_button_gesture_detector (
  input  logic              clk,
  input  logic              rst_n,
  lbgd_in_if.sink           in_ch,
  lbgd_out_if.source        out_ch,
  lbgd_cfg_if.sink          cfg_ch
);
  import lbgd_pkg::*;

  // threshold and timing registers
  logic [SAMPLE_W-1:0] released_min_r, first_max_r, second_min_r, second_max_r;
  logic [SAMPLE_W-1:0] third_min_r, third_max_r;
  logic [MS_W-1:0]     long_press_ms_r, double_click_ms_r;

  // input register
  logic                   in_vld_r;
  logic [SAMPLE_W-1:0]    in_a_r, in_b_r;
  logic [TIME_W-1:0]      in_now_r;
  logic [BTN_COUNT-1:0]   in_ack_r;

  // ladder state
  logic [BTN_W-1:0]  cand_r [NUM_LADDERS];
  logic [BTN_W-1:0]  dec_r  [NUM_LADDERS];
  logic [TIME_W-1:0] ct_r   [NUM_LADDERS];
  logic [BTN_W-1:0]  cand_nxt [NUM_LADDERS];
  logic [BTN_W-1:0]  dec_nxt  [NUM_LADDERS];
  logic [TIME_W-1:0] ct_nxt   [NUM_LADDERS];

  // button state
  logic [BTN_COUNT-1:0]   bd_r, ld_r, cp_r;
  logic [BTN_COUNT-1:0]   bd_nxt, ld_nxt, cp_nxt;
  logic [TIME_W-1:0]      ps_r [BTN_COUNT];
  logic [TIME_W-1:0]      rs_r [BTN_COUNT];
  logic [TIME_W-1:0]      ps_nxt [BTN_COUNT];
  logic [TIME_W-1:0]      rs_nxt [BTN_COUNT];
  event_t                 ev_r [BTN_COUNT];
  event_t                 ev_nxt [BTN_COUNT];
  event_t                 ev_work [BTN_COUNT];  // event as reported, before ack clearing

  // result register
  logic                   out_vld_r;
  event_t                 out_ev_r [BTN_COUNT];
  logic [BTN_COUNT-1:0]   out_pressed_r;
  logic [BTN_W-1:0]       out_a_r, out_b_r;

  logic in_xfer;
  logic adv;  // held item moves through the update pass into the result register

  // sort one sample into no button, ladder button 1..3, or keep the previous decision
  function automatic logic [BTN_W-1:0] classify(
    input logic [SAMPLE_W-1:0] s,
    input logic [BTN_W-1:0]    prev,
    input logic [SAMPLE_W-1:0] rel_min,
    input logic [SAMPLE_W-1:0] b1_max,
    input logic [SAMPLE_W-1:0] b2_min,
    input logic [SAMPLE_W-1:0] b2_max,
    input logic [SAMPLE_W-1:0] b3_min,
    input logic [SAMPLE_W-1:0] b3_max
  );
    logic [BTN_W-1:0] c;
    if (s >= rel_min) c = BTN_NONE;
    else if (s <= b1_max) c = BTN_FIRST;
    else if (s >= b2_min && s <= b2_max) c = BTN_SECOND;
    else if (s >= b3_min && s <= b3_max) c = BTN_THIRD;
    else c = prev;
    return c;
  endfunction

  // pressed mask implied by the two ladder decisions
  function automatic logic [BTN_COUNT-1:0] dec_mask(
    input logic [BTN_W-1:0] da,
    input logic [BTN_W-1:0] db
  );
    logic [BTN_COUNT-1:0] m;
    for (int j = 0; j < BTNS_PER_LADDER; j++) begin
      m[j]                   = (da == BTN_W'(j + 1));
      m[j + BTNS_PER_LADDER] = (db == BTN_W'(j + 1));
    end
    return m;
  endfunction

  // handshake: the input register refills whenever its item moves on
  assign adv          = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready  = !in_vld_r || adv;
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // single update pass over ladder and button state
  always_comb begin
    logic [BTN_W-1:0]  cls;
    logic [SAMPLE_W-1:0] smp;
    logic              pressed;
    logic [TIME_W-1:0] el;
    logic [TIME_W-1:0] dr;
    logic [MS_W:0]     hold_th;
    int                idx;

    hold_th = {1'b0, long_press_ms_r} + {1'b0, HOLD_REPEAT_MS};

    for (int k = 0; k < NUM_LADDERS; k++) begin
      cand_nxt[k] = cand_r[k];
      dec_nxt[k]  = dec_r[k];
      ct_nxt[k]   = ct_r[k];
    end
    bd_nxt = bd_r;
    ld_nxt = ld_r;
    cp_nxt = cp_r;
    for (int i = 0; i < BTN_COUNT; i++) begin
      ps_nxt[i]  = ps_r[i];
      rs_nxt[i]  = rs_r[i];
      ev_work[i] = ev_r[i];
    end

    // ladder classification and debounce
    for (int k = 0; k < NUM_LADDERS; k++) begin
      smp = (k == 0) ? in_a_r : in_b_r;
      cls = classify(smp, dec_r[k], released_min_r, first_max_r, second_min_r,
                     second_max_r, third_min_r, third_max_r);
      if (cls != cand_r[k]) begin
        cand_nxt[k] = cls;
        ct_nxt[k]   = in_now_r;
      end
      if (cls != dec_r[k] && (in_now_r - ct_nxt[k]) >= DEBOUNCE_MS) begin
        dec_nxt[k] = cls;
      end
    end

    // gesture machine per button
    for (int k = 0; k < NUM_LADDERS; k++) begin
      for (int j = 0; j < BTNS_PER_LADDER; j++) begin
        idx     = k * BTNS_PER_LADDER + j;
        pressed = (dec_nxt[k] == BTN_W'(j + 1));

        // press edge
        if (pressed && !bd_nxt[idx]) begin
          bd_nxt[idx] = 1'b1;
          ps_nxt[idx] = in_now_r;
          ld_nxt[idx] = 1'b0;
        end

        // long press, then periodic hold
        el = in_now_r - ps_nxt[idx];
        if (bd_nxt[idx]) begin
          if (!ld_nxt[idx]) begin
            if (el >= {16'b0, long_press_ms_r}) begin
              ev_work[idx] = EV_LONG;
              ld_nxt[idx]  = 1'b1;
            end
          end else begin
            if (el >= {15'b0, hold_th}) begin
              ev_work[idx] = EV_HOLD;
              ps_nxt[idx]  = in_now_r - {16'b0, long_press_ms_r};
            end
          end
        end

        // release edge: click bookkeeping (press stamp unchanged when no long press)
        if (!pressed && bd_nxt[idx]) begin
          bd_nxt[idx] = 1'b0;
          if (!ld_nxt[idx] && el >= DEBOUNCE_MS) begin
            if (!cp_nxt[idx]) begin
              cp_nxt[idx] = 1'b1;
              rs_nxt[idx] = in_now_r;
            end else if ((in_now_r - rs_r[idx]) <= {16'b0, double_click_ms_r}) begin
              cp_nxt[idx]  = 1'b0;
              ev_work[idx] = EV_DOUBLE;
            end else begin
              cp_nxt[idx] = 1'b1;
              rs_nxt[idx] = in_now_r;
            end
          end
        end

        // double click window ran out: single short press
        dr = in_now_r - rs_nxt[idx];
        if (!bd_nxt[idx] && cp_nxt[idx] && dr > {16'b0, double_click_ms_r}) begin
          cp_nxt[idx] = 1'b0;
          if (ev_work[idx] == EV_NONE) ev_work[idx] = EV_SHORT;
        end
      end
    end

    // acknowledged events clear after the report
    for (int i = 0; i < BTN_COUNT; i++) begin
      ev_nxt[i] = in_ack_r[i] ? EV_NONE : ev_work[i];
    end
  end

  // control, state and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r          <= 1'b0;
      out_vld_r         <= 1'b0;
      released_min_r    <= RST_RELEASED_MIN;
      first_max_r       <= RST_FIRST_MAX;
      second_min_r      <= RST_SECOND_MIN;
      second_max_r      <= RST_SECOND_MAX;
      third_min_r       <= RST_THIRD_MIN;
      third_max_r       <= RST_THIRD_MAX;
      long_press_ms_r   <= RST_LONG_PRESS_MS;
      double_click_ms_r <= RST_DOUBLE_CLICK_MS;
      for (int k = 0; k < NUM_LADDERS; k++) begin
        cand_r[k] <= BTN_NONE;
        dec_r[k]  <= BTN_NONE;
        ct_r[k]   <= '0;
      end
      bd_r <= '0;
      ld_r <= '0;
      cp_r <= '0;
      for (int i = 0; i < BTN_COUNT; i++) begin
        ps_r[i] <= '0;
        rs_r[i] <= '0;
        ev_r[i] <= EV_NONE;
      end
    end else begin
      // input register valid
      if (in_xfer) in_vld_r <= 1'b1;
      else if (adv) in_vld_r <= 1'b0;

      // result register valid
      if (adv) out_vld_r <= 1'b1;
      else if (out_ch.ready) out_vld_r <= 1'b0;

      // state commits once per item
      if (adv) begin
        for (int k = 0; k < NUM_LADDERS; k++) begin
          cand_r[k] <= cand_nxt[k];
          dec_r[k]  <= dec_nxt[k];
          ct_r[k]   <= ct_nxt[k];
        end
        bd_r <= bd_nxt;
        ld_r <= ld_nxt;
        cp_r <= cp_nxt;
        for (int i = 0; i < BTN_COUNT; i++) begin
          ps_r[i] <= ps_nxt[i];
          rs_r[i] <= rs_nxt[i];
          ev_r[i] <= ev_nxt[i];
        end
      end

      // register writes; unknown indexes cannot occur with a 3-bit index
      if (cfg_ch.valid) begin
        case (cfg_idx_t'(cfg_ch.addr))
          CFG_RELEASED_MIN:    released_min_r    <= cfg_ch.data[SAMPLE_W-1:0];
          CFG_FIRST_MAX:       first_max_r       <= cfg_ch.data[SAMPLE_W-1:0];
          CFG_SECOND_MIN:      second_min_r      <= cfg_ch.data[SAMPLE_W-1:0];
          CFG_SECOND_MAX:      second_max_r      <= cfg_ch.data[SAMPLE_W-1:0];
          CFG_THIRD_MIN:       third_min_r       <= cfg_ch.data[SAMPLE_W-1:0];
          CFG_THIRD_MAX:       third_max_r       <= cfg_ch.data[SAMPLE_W-1:0];
          CFG_LONG_PRESS_MS:   long_press_ms_r   <= cfg_ch.data;
          CFG_DOUBLE_CLICK_MS: double_click_ms_r <= cfg_ch.data;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_a_r   <= in_ch.ladder_a_sample;
      in_b_r   <= in_ch.ladder_b_sample;
      in_now_r <= in_ch.now_ms;
      in_ack_r <= in_ch.ack_mask;
    end
    if (adv) begin
      for (int i = 0; i < BTN_COUNT; i++) begin
        out_ev_r[i] <= ev_work[i];
      end
      out_pressed_r <= bd_nxt;
      out_a_r       <= dec_nxt[0];
      out_b_r       <= dec_nxt[1];
    end
  end

  assign out_ch.valid           = out_vld_r;
  assign out_ch.event_b1        = out_ev_r[0];
  assign out_ch.event_b2        = out_ev_r[1];
  assign out_ch.event_b3        = out_ev_r[2];
  assign out_ch.event_b4        = out_ev_r[3];
  assign out_ch.event_b5        = out_ev_r[4];
  assign out_ch.event_b6        = out_ev_r[5];
  assign out_ch.pressed_mask    = out_pressed_r;
  assign out_ch.ladder_a_button = out_a_r;
  assign out_ch.ladder_b_button = out_b_r;

`ifndef SYNTHESIS
  // an empty result register never blocks the input side
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_vld_r |-> in_ch.ready)
    else $error("input stalled with empty result register");

  // every item that leaves the input register lands in the result register
  a_adv_fills_result: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_vld_r)
    else $error("result register not loaded after update pass");

  // a button counts as pressed exactly when its ladder decision selects it
  a_pressed_matches_decision: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_pressed_r == dec_mask(out_a_r, out_b_r)))
    else $error("pressed mask disagrees with ladder decisions");

  // a stalled result keeps the button state frozen
  a_state_frozen_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_ch.ready) |=> ($stable(bd_r) && $stable(ld_r) && $stable(cp_r)))
    else $error("button state changed while result stalled");
`endif

endmodule
